[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every active clock edge.
`define DRLP_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define DRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/drlp_pkg.sv]
// ----------------------------------------------------------------------------
// Depth range list parser package
// Types, character codes, status codes and helper functions of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package drlp_pkg;

   // Width of the numbers held while parsing, and of the result depth fields.
   localparam int VALUE_BITS = 32;
   localparam int DEPTH_BITS = 32;

   // Result queue geometry; the depth is a power of two so pointers wrap.
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int LEVEL_BITS = $clog2(FIFO_DEPTH + 1);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [DEPTH_BITS-1:0] depth_type;

   localparam value_type VALUE_MAX = '1;

   // Character codes.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      ST_PAIR        = 3'd0,
      ST_END_OK      = 3'd1,
      ST_REVERSED    = 3'd2,
      ST_LOW_ZERO    = 3'd3,
      ST_HIGH_ZERO   = 3'd4,
      ST_SINGLE_ZERO = 3'd5,
      ST_SYNTAX      = 3'd6
   } status_type;

   // One result as it leaves the block.
   typedef struct packed {
      status_type status;
      depth_type  low_depth;
      depth_type  high_depth;
      logic       final_res;
   } result_type;

   // Up to two results produced by one request.
   typedef struct packed {
      logic       first_v;
      logic       second_v;
      result_type first;
      result_type second;
   } push_type;

   // Decimal accumulate with saturation at the largest value.
   function automatic value_type accumulate(value_type v, logic [3:0] d);
      logic [VALUE_BITS+3:0] wide;
      begin
         wide = {3'b000, v, 1'b0} + {v, 3'b000} + {{VALUE_BITS{1'b0}}, d};
         if (wide > {4'b0000, VALUE_MAX}) begin
            return VALUE_MAX;
         end
         return wide[VALUE_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[rtl/core/drlp_parse_core.sv]
// ----------------------------------------------------------------------------
// Parser core
// Holds the parse state and turns one character into zero, one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module drlp_parse_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         text_byte,
   output      drlp_pkg::push_type push
);
   import drlp_pkg::*;

   typedef enum logic [6:0] {
      PH_START   = 7'b0000001,
      PH_BETWEEN = 7'b0000010,
      PH_NUM1    = 7'b0000100,
      PH_DASH    = 7'b0001000,
      PH_NUM2    = 7'b0010000,
      PH_LEAD    = 7'b0100000,
      PH_LEADNUM = 7'b1000000
   } phase_type;

   phase_type  phase_ff, phase_in;
   value_type  first_ff, first_in;
   value_type  second_ff, second_in;
   value_type  prev_ff, prev_in;
   logic       failed_ff, failed_in;

   logic       is_nul, is_space, is_comma, is_dash, dig;
   logic [3:0] digit;
   logic       emit, btw, btw_start, tail_v, tail_err, clr;
   value_type  emit_lo, emit_hi;
   status_type tail_code;
   result_type pair_res, tail_res;

   // Character classes.
   always_comb begin
      is_nul   = (text_byte == CH_NUL);
      is_space = (text_byte inside {CH_SPACE, [CH_TAB:CH_CR]});
      is_comma = (text_byte == CH_COMMA);
      is_dash  = (text_byte == CH_DASH);
      dig      = (text_byte inside {[CH_ZERO:CH_NINE]});
      digit    = dig ? 4'(text_byte - CH_ZERO) : 4'd0;
   end

   // Next state and results for the current character.
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      prev_in   = prev_ff;
      failed_in = failed_ff;
      emit      = 1'b0;
      emit_lo   = '0;
      emit_hi   = '0;
      btw       = 1'b0;
      btw_start = 1'b0;
      tail_v    = 1'b0;
      tail_err  = 1'b0;
      tail_code = ST_PAIR;
      clr       = 1'b0;

      if (failed_ff) begin
         // After an error everything up to the terminating NUL is dropped.
         clr = is_nul;
      end else begin
         case (phase_ff)
            PH_NUM1: begin
               if (dig) begin
                  first_in = accumulate(first_ff, digit);
               end else if (is_dash) begin
                  phase_in = PH_DASH;
               end else if (first_ff == '0) begin
                  tail_err  = 1'b1;
                  tail_code = ST_SINGLE_ZERO;
               end else begin
                  emit    = 1'b1;
                  emit_lo = prev_ff + 1'b1;
                  emit_hi = first_ff;
                  btw     = 1'b1;
               end
            end
            PH_DASH: begin
               if (dig) begin
                  second_in = VALUE_BITS'(digit);
                  phase_in  = PH_NUM2;
               end else if (first_ff == '0) begin
                  tail_err  = 1'b1;
                  tail_code = ST_LOW_ZERO;
               end else begin
                  emit    = 1'b1;
                  emit_lo = first_ff;
                  btw     = 1'b1;
               end
            end
            PH_NUM2: begin
               if (dig) begin
                  second_in = accumulate(second_ff, digit);
               end else if (first_ff > second_ff) begin
                  tail_err  = 1'b1;
                  tail_code = ST_REVERSED;
               end else if (first_ff == '0) begin
                  tail_err  = 1'b1;
                  tail_code = ST_LOW_ZERO;
               end else begin
                  emit    = 1'b1;
                  emit_lo = first_ff;
                  emit_hi = second_ff;
                  btw     = 1'b1;
               end
            end
            PH_LEAD: begin
               if (dig) begin
                  second_in = VALUE_BITS'(digit);
                  phase_in  = PH_LEADNUM;
               end else begin
                  tail_err  = 1'b1;
                  tail_code = ST_SYNTAX;
               end
            end
            PH_LEADNUM: begin
               if (dig) begin
                  second_in = accumulate(second_ff, digit);
               end else if (second_ff == '0) begin
                  tail_err  = 1'b1;
                  tail_code = ST_HIGH_ZERO;
               end else begin
                  emit    = 1'b1;
                  emit_lo = VALUE_BITS'(1);
                  emit_hi = second_ff;
                  btw     = 1'b1;
               end
            end
            PH_START: begin
               btw       = 1'b1;
               btw_start = 1'b1;
            end
            default: begin
               phase_in = PH_BETWEEN;
               btw      = 1'b1;
            end
         endcase
      end

      // A finished entry records its high limit and returns to between entries.
      if (emit) begin
         prev_in  = emit_hi;
         phase_in = PH_BETWEEN;
      end

      // Handling of a character where a new entry may begin.
      if (btw) begin
         if (is_nul) begin
            tail_v    = 1'b1;
            tail_code = ST_END_OK;
            clr       = 1'b1;
         end else if (is_space) begin
            phase_in = phase_in;
         end else if (is_comma) begin
            if (btw_start) begin
               tail_err  = 1'b1;
               tail_code = ST_SYNTAX;
            end
         end else if (dig) begin
            first_in = VALUE_BITS'(digit);
            phase_in = PH_NUM1;
         end else if (is_dash) begin
            phase_in = PH_LEAD;
         end else begin
            tail_err  = 1'b1;
            tail_code = ST_SYNTAX;
         end
      end

      // An error closes the string now on NUL, else drops input until NUL.
      if (tail_err) begin
         tail_v = 1'b1;
         if (is_nul) begin
            clr = 1'b1;
         end else begin
            failed_in = 1'b1;
         end
      end

      if (clr) begin
         phase_in  = PH_START;
         first_in  = '0;
         second_in = '0;
         prev_in   = '0;
         failed_in = 1'b0;
      end
   end

   // Results in emission order: a pair first, then an end or error result.
   always_comb begin
      pair_res.status     = ST_PAIR;
      pair_res.low_depth  = DEPTH_BITS'(emit_lo);
      pair_res.high_depth = DEPTH_BITS'(emit_hi);
      pair_res.final_res  = 1'b0;

      tail_res.status     = tail_code;
      tail_res.low_depth  = '0;
      tail_res.high_depth = '0;
      tail_res.final_res  = 1'b1;

      push.first_v  = step && (emit || tail_v);
      push.second_v = step && emit && tail_v;
      push.first    = emit ? pair_res : tail_res;
      push.second   = tail_res;
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         first_ff  <= '0;
         second_ff <= '0;
         prev_ff   <= '0;
         failed_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         prev_ff   <= prev_in;
         failed_ff <= failed_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/drlp_result_fifo.sv]
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results a cycle and hands out one a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module drlp_result_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire drlp_pkg::push_type   push,
   output      logic                 room,
   output      logic                 out_valid,
   input  wire logic                 out_stall,
   output      drlp_pkg::result_type out_data
);
   import drlp_pkg::*;

   result_type            q_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [PTR_BITS-1:0]   wr_next;
   logic [LEVEL_BITS-1:0] push_cnt;
   logic                  pop;

   // Room for a full pair of results, judged on registered state only.
   assign room      = (level_ff <= LEVEL_BITS'(FIFO_DEPTH - 2));
   assign out_valid = (level_ff != '0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   // Pointer and level bookkeeping.
   always_comb begin
      wr_next   = wr_ptr_ff + 1'b1;
      push_cnt  = LEVEL_BITS'(push.first_v) + LEVEL_BITS'(push.second_v);
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + push_cnt - LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push.first_v) begin
         q_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_v) begin
         q_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

[rtl/core/depth_range_list_parser_top.sv]
// A request waits in the input register, then its results go through the queue to the port.
// Throughput: one request per cycle while rsp_stall is low and each yields at most one
// response; the port moves one a cycle, so requests yielding two slow intake to that pace.
// A four-entry result queue decouples the sides; intake pauses when fewer than two are free.
// Reset is synchronous and active high; it clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
// Depth range list parser
// Parses a text list of depth ranges, one character per request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module depth_range_list_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_text_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_status,
   output      logic [31:0] rsp_low_depth,
   output      logic [31:0] rsp_high_depth,
   output      logic        rsp_final_res
);
   import drlp_pkg::*;

   logic       in_v_ff, in_v_in;
   logic [7:0] in_byte_ff;
   logic       room, step, accept;
   push_type   push;
   result_type out_data;

   // Input register: a held character moves into the core when the queue has room.
   assign step      = in_v_ff && room;
   assign req_stall = in_v_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_v_in   = accept || (in_v_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_text_byte;
      end
   end

   drlp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .text_byte (in_byte_ff),
      .push      (push)
   );

   drlp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   // Response fields.
   assign rsp_status     = out_data.status;
   assign rsp_low_depth  = out_data.low_depth;
   assign rsp_high_depth = out_data.high_depth;
   assign rsp_final_res  = out_data.final_res;

   // A held character waits in place while the queue lacks room for two results.
   `DRLP_ASSERT_NEXT(a_hold_input, in_v_ff && !room, in_v_ff && $stable(in_byte_ff), "held request lost")
   // A second result only ever follows a first one.
   `DRLP_ASSERT(a_second_after_first, !push.second_v || push.first_v, "second result without first")
   // The second result of a request always closes the string.
   `DRLP_ASSERT(a_second_final, !push.second_v || push.second.final_res, "second result not final")

endmodule

`default_nettype wire
